>>> src/haversine_distance_top_macros.svh
// ----------------------------------------------------------------------------
// haversine distance assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_TOP_MACROS_SVH
`define HAVERSINE_DISTANCE_TOP_MACROS_SVH

// checked outside reset only
`define HVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define HVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// constants, types and table functions for the haversine distance pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int SQRT_BITS     = 31;
  localparam int SQ_W          = 2 * SQRT_BITS - 1;
  localparam int ANG_W         = 35;
  localparam int ROT_W         = 33;
  localparam int VEC_W         = 34;
  localparam int RAD_W         = 24;
  localparam int DIST_W        = 26;
  localparam int LATENCY       = 16 + SQRT_BITS + 2 * CORDIC_STAGES;

  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_PER_DEG = (PI_Q60 / 64'd180 + (64'd1 << 21)) >> 22;
  localparam logic [15:0] RC_LO       = RAD_PER_DEG[15:0];
  localparam logic [16:0] RC_HI       = RAD_PER_DEG[32:16];

  localparam logic signed [ROT_W-1:0] KINV_Q30 = 33'sd652032874;
  localparam logic [RAD_W-1:0]        RADIUS_RESET = 24'd6371000;
  localparam logic [30:0]             ONE_Q30 = 31'd1073741824;

  localparam logic signed [32:0] DEG_FULL = 33'sd1509949440;
  localparam logic signed [32:0] DEG_HALF = 33'sd754974720;
  localparam logic [29:0]        DEG_HALF_U    = 30'd754974720;
  localparam logic [29:0]        DEG_QUARTER_U = 30'd377487360;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [ROT_W-1:0] rot_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  // atan(2^-i) in q32, from a q62 series sum
  function automatic ang_t atan_q32(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    int          e;
    int          k;
    sum = '0;
    if (i == 0) begin
      sum = (PI_Q60 + (64'd1 << 29)) >> 30;
    end else begin
      for (k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if (k[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      sum = (sum + (64'd1 << 29)) >> 30;
    end
    return ANG_W'(sum);
  endfunction

endpackage

`default_nettype wire

>>> src/hvd_rot.sv
// ----------------------------------------------------------------------------
// hvd_rot
// pipelined circular cordic in rotation mode, one stage per register
// ----------------------------------------------------------------------------
`default_nettype none

module hvd_rot import hvd_pkg::*; (
  input  logic clk_i,
  input  ang_t z_i,
  output rot_t cos_o,
  output rot_t sin_o
);

  rot_t x_q [CORDIC_STAGES];
  rot_t y_q [CORDIC_STAGES];
  ang_t z_q [CORDIC_STAGES-1];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    localparam ang_t ATAN_G = atan_q32(g);
    rot_t x_in;
    rot_t y_in;
    ang_t z_in;
    logic pos;

    if (g == 0) begin : g_first
      assign x_in = KINV_Q30;
      assign y_in = '0;
      assign z_in = z_i;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign y_in = y_q[g-1];
      assign z_in = z_q[g-1];
    end

    assign pos = !z_in[ANG_W-1];

    always_ff @(posedge clk_i) begin
      if (pos) begin
        x_q[g] <= x_in - (y_in >>> g);
        y_q[g] <= y_in + (x_in >>> g);
      end else begin
        x_q[g] <= x_in + (y_in >>> g);
        y_q[g] <= y_in - (x_in >>> g);
      end
    end

    if (g < CORDIC_STAGES - 1) begin : g_ang
      always_ff @(posedge clk_i) begin
        z_q[g] <= pos ? z_in - ATAN_G : z_in + ATAN_G;
      end
    end
  end

  assign cos_o = x_q[CORDIC_STAGES-1];
  assign sin_o = y_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

>>> src/haversine_distance_top.sv
// ----------------------------------------------------------------------------
// haversine_distance_top
// great circle distance between two points, fully pipelined cordic datapath
// ----------------------------------------------------------------------------
// a request is taken on each rising edge with start_i high and busy_o low;
// busy_o stays low, so a new point pair may enter every cycle
// coordinates are degrees times 2^22, two's complement
// done_o pulses for one cycle with distance_o; between the accepting edge and
// the result lie the front end, the rotation cordic, products and clamp, the
// square roots, the vectoring cordic and the scaling registers, in that order
// results leave in request order, one per request
// the receiver cannot stall: done_o is a strobe and is never held
// sphere_radius_we_i writes the radius (reset value 6371000); write it only
// while no request is in flight
// reset clears the valid pipeline and restores the radius; requests in flight
// are dropped
// ----------------------------------------------------------------------------
`default_nettype none

module haversine_distance_top import hvd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [29:0]       first_latitude_i,
  input  logic signed [30:0]       first_longitude_i,
  input  logic signed [29:0]       second_latitude_i,
  input  logic signed [30:0]       second_longitude_i,
  input  logic                     sphere_radius_we_i,
  input  logic [RAD_W-1:0]         sphere_radius_i,
  output logic                     done_o,
  output logic [DIST_W-1:0]        distance_o
);

  function automatic logic signed [32:0] wrap_turn(input logic signed [32:0] d);
    logic signed [32:0] dm;
    logic signed [32:0] dp;
    dm = d - DEG_FULL;
    dp = d + DEG_FULL;
    if (d >= -DEG_HALF && d <= DEG_HALF) begin
      return d;
    end else if (dm >= -DEG_HALF && dm <= DEG_HALF) begin
      return dm;
    end else begin
      return dp;
    end
  endfunction

  function automatic rot_t rnd30(input logic signed [2*ROT_W-1:0] p);
    logic signed [2*ROT_W-1:0] t;
    t = p + (66'sd1 <<< 29);
    return ROT_W'(t >>> 30);
  endfunction

  logic                    accept;
  logic [RAD_W-1:0]        radius_q;
  logic [LATENCY-1:0]      vld_q;

  assign accept = start_i && !busy_o;
  assign busy_o = 1'b0;
  assign done_o = vld_q[LATENCY-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      vld_q    <= '0;
    end else begin
      if (sphere_radius_we_i) begin
        radius_q <= sphere_radius_i;
      end
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  // front end
  logic signed [29:0] s1_lat1_q, s1_lat2_q;
  logic signed [30:0] s1_lon1_q, s1_lon2_q;
  logic signed [32:0] s2_dlat_q, s2_dlon_q;
  logic [29:0]        s2_mag1_q, s2_mag2_q;
  logic signed [32:0] s3_wlat_q, s3_wlon_q;
  logic [29:0]        s3_u1_q, s3_u2_q;
  logic [29:0]        u_q  [4];
  logic [45:0]        lo_q [4];
  logic [46:0]        hi_q [4];
  ang_t               ang_q [4];
  logic [1:0]         flp_q [CORDIC_STAGES+4];

  always_ff @(posedge clk_i) begin
    s1_lat1_q <= first_latitude_i;
    s1_lon1_q <= first_longitude_i;
    s1_lat2_q <= second_latitude_i;
    s1_lon2_q <= second_longitude_i;

    s2_dlat_q <= 33'(s1_lat2_q) - 33'(s1_lat1_q);
    s2_dlon_q <= 33'(s1_lon2_q) - 33'(s1_lon1_q);
    s2_mag1_q <= s1_lat1_q[29] ? 30'(-s1_lat1_q) : 30'(s1_lat1_q);
    s2_mag2_q <= s1_lat2_q[29] ? 30'(-s1_lat2_q) : 30'(s1_lat2_q);

    s3_wlat_q <= wrap_turn(s2_dlat_q);
    s3_wlon_q <= wrap_turn(s2_dlon_q);
    s3_u1_q   <= (s2_mag1_q > DEG_QUARTER_U) ? DEG_HALF_U - s2_mag1_q : s2_mag1_q;
    s3_u2_q   <= (s2_mag2_q > DEG_QUARTER_U) ? DEG_HALF_U - s2_mag2_q : s2_mag2_q;
    flp_q[0]  <= {s2_mag2_q > DEG_QUARTER_U, s2_mag1_q > DEG_QUARTER_U};

    u_q[0] <= s3_wlat_q[32] ? 30'(-s3_wlat_q) : 30'(s3_wlat_q);
    u_q[1] <= s3_wlon_q[32] ? 30'(-s3_wlon_q) : 30'(s3_wlon_q);
    u_q[2] <= s3_u1_q;
    u_q[3] <= s3_u2_q;

    for (int k = 1; k < CORDIC_STAGES + 4; k++) begin
      flp_q[k] <= flp_q[k-1];
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_conv
    logic [63:0] sum;
    assign sum = {hi_q[l], 16'b0} + 64'(lo_q[l]);
    always_ff @(posedge clk_i) begin
      lo_q[l] <= 46'(u_q[l]) * 46'(RC_LO);
      hi_q[l] <= 47'(u_q[l]) * 47'(RC_HI);
      if (l < 2) begin
        ang_q[l] <= ANG_W'((sum + (64'd1 << 28)) >> 29);
      end else begin
        ang_q[l] <= ANG_W'((sum + (64'd1 << 27)) >> 28);
      end
    end
  end

  // sines and cosines
  rot_t sin_lat_w, sin_lon_w, cos1_w, cos2_w;

  hvd_rot u_rot_dlat (.clk_i(clk_i), .z_i(ang_q[0]), .cos_o(), .sin_o(sin_lat_w));
  hvd_rot u_rot_dlon (.clk_i(clk_i), .z_i(ang_q[1]), .cos_o(), .sin_o(sin_lon_w));
  hvd_rot u_rot_lat1 (.clk_i(clk_i), .z_i(ang_q[2]), .cos_o(cos1_w), .sin_o());
  hvd_rot u_rot_lat2 (.clk_i(clk_i), .z_i(ang_q[3]), .cos_o(cos2_w), .sin_o());

  // haversine term
  rot_t                      q1_slat_q, q1_slon_q, q1_c1_q, q1_c2_q;
  logic signed [2*ROT_W-1:0] q2_plat_q, q2_plon_q, q2_pcc_q;
  rot_t                      q3_hlat_q, q3_hlon_q, q3_cc_q;
  logic signed [2*ROT_W-1:0] q4_m_q;
  rot_t                      q4_hlat_q, q5_hlat_q, q5_mr_q;
  logic signed [33:0]        a_sum;
  logic [30:0]               q6_a_q;
  logic [30:0]               sq_in_q [2];

  assign a_sum = 34'(q5_hlat_q) + 34'(q5_mr_q);

  always_ff @(posedge clk_i) begin
    q1_slat_q <= sin_lat_w;
    q1_slon_q <= sin_lon_w;
    q1_c1_q   <= flp_q[CORDIC_STAGES+3][0] ? -cos1_w : cos1_w;
    q1_c2_q   <= flp_q[CORDIC_STAGES+3][1] ? -cos2_w : cos2_w;

    q2_plat_q <= q1_slat_q * q1_slat_q;
    q2_plon_q <= q1_slon_q * q1_slon_q;
    q2_pcc_q  <= q1_c1_q * q1_c2_q;

    q3_hlat_q <= rnd30(q2_plat_q);
    q3_hlon_q <= rnd30(q2_plon_q);
    q3_cc_q   <= rnd30(q2_pcc_q);

    q4_m_q    <= q3_cc_q * q3_hlon_q;
    q4_hlat_q <= q3_hlat_q;

    q5_mr_q   <= rnd30(q4_m_q);
    q5_hlat_q <= q4_hlat_q;

    if (a_sum < 0) begin
      q6_a_q <= '0;
    end else if (a_sum > 34'(ONE_Q30)) begin
      q6_a_q <= ONE_Q30;
    end else begin
      q6_a_q <= 31'(a_sum);
    end

    sq_in_q[0] <= q6_a_q;
    sq_in_q[1] <= ONE_Q30 - q6_a_q;
  end

  // square roots, one result bit per stage
  logic [SQ_W-1:0]      sq_rem_q  [2][SQRT_BITS-1];
  logic [SQRT_BITS-1:0] sq_root_q [2][SQRT_BITS];

  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_bit
      localparam int BITPOS = SQRT_BITS - 1 - j;
      logic [SQ_W-1:0]      rem_in;
      logic [SQRT_BITS-1:0] root_in;
      logic [SQ_W:0]        cand;
      logic                 take;

      if (j == 0) begin : g_first
        assign rem_in  = {sq_in_q[l], (SQRT_BITS-1)'(0)};
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = sq_rem_q[l][j-1];
        assign root_in = sq_root_q[l][j-1];
      end

      assign cand = ((SQ_W+1)'(root_in) << (BITPOS + 1)) | ((SQ_W+1)'(1) << (2 * BITPOS));
      assign take = {1'b0, rem_in} >= cand;

      always_ff @(posedge clk_i) begin
        sq_root_q[l][j] <= take ? (root_in | (SQRT_BITS'(1) << BITPOS)) : root_in;
      end

      if (j < SQRT_BITS - 1) begin : g_rem
        always_ff @(posedge clk_i) begin
          sq_rem_q[l][j] <= take ? rem_in - cand[SQ_W-1:0] : rem_in;
        end
      end
    end
  end

  // central angle by vectoring
  vec_t xv_q [CORDIC_STAGES-1];
  vec_t yv_q [CORDIC_STAGES-1];
  ang_t zv_q [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
    localparam ang_t ATAN_G = atan_q32(g);
    vec_t x_in;
    vec_t y_in;
    ang_t z_in;
    logic y_pos;
    logic y_neg;

    if (g == 0) begin : g_first
      assign x_in = VEC_W'(sq_root_q[1][SQRT_BITS-1]);
      assign y_in = VEC_W'(sq_root_q[0][SQRT_BITS-1]);
      assign z_in = '0;
    end else begin : g_next
      assign x_in = xv_q[g-1];
      assign y_in = yv_q[g-1];
      assign z_in = zv_q[g-1];
    end

    assign y_neg = y_in[VEC_W-1];
    assign y_pos = !y_neg && (y_in != '0);

    always_ff @(posedge clk_i) begin
      if (y_pos) begin
        zv_q[g] <= z_in + ATAN_G;
      end else if (y_neg) begin
        zv_q[g] <= z_in - ATAN_G;
      end else begin
        zv_q[g] <= z_in;
      end
    end

    if (g < CORDIC_STAGES - 1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (y_pos) begin
          xv_q[g] <= x_in + (y_in >>> g);
          yv_q[g] <= y_in - (x_in >>> g);
        end else if (y_neg) begin
          xv_q[g] <= x_in - (y_in >>> g);
          yv_q[g] <= y_in + (x_in >>> g);
        end else begin
          xv_q[g] <= x_in;
          yv_q[g] <= y_in;
        end
      end
    end
  end

  // scale by radius
  logic [ANG_W-2:0]             r1_z_q;
  logic [ANG_W+RAD_W-2:0]       r2_p_q;
  logic [ANG_W+RAD_W-2:0]       r3_sum;
  logic [DIST_W-1:0]            distance_q;

  assign r3_sum = r2_p_q + ((ANG_W+RAD_W-1)'(1) << 30);

  always_ff @(posedge clk_i) begin
    r1_z_q     <= zv_q[CORDIC_STAGES-1][ANG_W-1] ? '0 : zv_q[CORDIC_STAGES-1][ANG_W-2:0];
    r2_p_q     <= (ANG_W+RAD_W-1)'(r1_z_q) * (ANG_W+RAD_W-1)'(radius_q);
    distance_q <= r3_sum[31 +: DIST_W];
  end

  assign distance_o = distance_q;

endmodule

`default_nettype wire

>>> src/haversine_distance_checker.sv
// ----------------------------------------------------------------------------
// haversine_distance_assert
// port level checks on request and result timing and on zero distance for equal points
// ----------------------------------------------------------------------------
`default_nettype none

`include "haversine_distance_top_macros.svh"

module haversine_distance_assert import hvd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [29:0] first_latitude_i,
  input logic signed [30:0] first_longitude_i,
  input logic signed [29:0] second_latitude_i,
  input logic signed [30:0] second_longitude_i,
  input logic               done_o,
  input logic [DIST_W-1:0]  distance_o
);

  `HVD_ASSERT(a_result_has_request, done_o |-> $past(start_i && !busy_o, LATENCY), "result without request")
  `HVD_ASSERT(a_request_gives_result, (start_i && !busy_o) |-> ##LATENCY done_o, "request lost")
  `HVD_ASSERT(a_same_point_zero, (start_i && !busy_o && first_latitude_i == second_latitude_i && first_longitude_i == second_longitude_i) |-> ##LATENCY (distance_o == '0), "same point not zero")
  `HVD_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised")

endmodule

bind haversine_distance_top haversine_distance_assert u_checker (.*);

`default_nettype wire

>>> dv/haversine_distance_checker.sv
// ----------------------------------------------------------------------------
// haversine_distance_checker
// watches requests and distance strobes, predicts each distance with a
// fixed-point cordic model of its own and compares results in request order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module haversine_distance_checker import hvd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [29:0] first_latitude_i,
  input  logic signed [30:0] first_longitude_i,
  input  logic signed [29:0] second_latitude_i,
  input  logic signed [30:0] second_longitude_i,
  input  logic               sphere_radius_we_i,
  input  logic [RAD_W-1:0]   sphere_radius_i,
  input  logic               done_i,
  input  logic [DIST_W-1:0]  distance_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);

  localparam int NSTAGE = CORDIC_STAGES;
  localparam longint FULL_TURN    = 64'sd1509949440;
  localparam longint HALF_TURN    = 64'sd754974720;
  localparam longint QUARTER_TURN = 64'sd377487360;
  localparam longint UNIT_Q30     = 64'sd1 << 30;

  longint          arctan_q32 [40];
  longint          deg_to_rad;
  logic [RAD_W-1:0] radius;
  logic [DIST_W-1:0] expected_dist_q[$];

  initial begin
    longint unsigned sum;
    longint unsigned term;
    int e;
    arctan_q32[0] = longint'((64'h3243F6A8885A308D + (64'd1 << 29)) >> 30);
    for (int i = 1; i < 40; i++) begin
      sum = 0;
      for (int k = 0; 62 - i * (2 * k + 1) >= 0; k++) begin
        e = 62 - i * (2 * k + 1);
        term = (64'd1 << e) / longint'(2 * k + 1);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      arctan_q32[i] = longint'((sum + (64'd1 << 29)) >> 30);
    end
    deg_to_rad = longint'((64'h3243F6A8885A308D / 64'd180 + (64'd1 << 21)) >> 22);
  end

  function automatic longint rnd_q30(longint v);
    return (v + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic void cordic_rotate(longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q32[i];
      end else begin
        x += dx; y -= dy; z += arctan_q32[i];
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint cordic_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < NSTAGE; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q32[i];
      end else if (y < 0) begin
        x -= dx; y += dy; z -= arctan_q32[i];
      end
    end
    return z;
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint half_sin_sq(longint d);
    longint r, c, s;
    r = d % FULL_TURN;
    if (r > HALF_TURN) r -= FULL_TURN;
    if (r < -HALF_TURN) r += FULL_TURN;
    if (r < 0) r = -r;
    cordic_rotate((r * deg_to_rad + (64'sd1 << 28)) >>> 29, c, s);
    return rnd_q30(s * s);
  endfunction

  function automatic longint lat_cosine(longint v);
    longint u, c, s;
    bit flip;
    u = v < 0 ? -v : v;
    flip = 0;
    if (u > QUARTER_TURN) begin
      u = HALF_TURN - u;
      flip = 1;
    end
    cordic_rotate((u * deg_to_rad + (64'sd1 << 27)) >>> 28, c, s);
    return flip ? -c : c;
  endfunction

  function automatic logic [DIST_W-1:0] great_circle_distance(
    longint lat1, longint lon1, longint lat2, longint lon2, logic [RAD_W-1:0] r);
    longint hav, sa, sb, z;
    longint unsigned d;
    hav = half_sin_sq(lat2 - lat1)
        + rnd_q30(rnd_q30(lat_cosine(lat1) * lat_cosine(lat2)) * half_sin_sq(lon2 - lon1));
    if (hav < 0) hav = 0;
    if (hav > UNIT_Q30) hav = UNIT_Q30;
    sa = isqrt(longint'(hav) << 30);
    sb = isqrt(longint'(UNIT_Q30 - hav) << 30);
    z = cordic_angle(sb, sa);
    if (z < 0) z = 0;
    d = (longint'(z) * longint'({40'd0, r}) + (64'd1 << 30)) >> 31;
    return d[DIST_W-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
    $display("%0t checker: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count_o++;
  endtask

  initial mismatch_count_o = 0;
  assign pending_o = expected_dist_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_dist_q.delete();
      radius <= RADIUS_RESET;
    end else begin
      if (sphere_radius_we_i) radius <= sphere_radius_i;
      if (start_i && !busy_i) begin
        expected_dist_q.push_back(great_circle_distance(first_latitude_i, first_longitude_i,
          second_latitude_i, second_longitude_i, radius));
      end
      if (done_i) begin
        if (expected_dist_q.size() == 0) report_mismatch("unexpected distance", distance_i, '0);
        else if (distance_i !== expected_dist_q[0])
          report_mismatch("distance", distance_i, expected_dist_q.pop_front());
        else void'(expected_dist_q.pop_front());
      end
    end
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives point pairs and radius writes into the haversine distance pipeline
// through directed corners and four random phases of varying sender idling
`timescale 1ns / 100ps

module tb;
  import hvd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;
  localparam int LAT_MAX = 377487360;
  localparam int LON_MAX = 754974720;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic               busy_o;
  logic signed [29:0] first_latitude_i = '0;
  logic signed [30:0] first_longitude_i = '0;
  logic signed [29:0] second_latitude_i = '0;
  logic signed [30:0] second_longitude_i = '0;
  logic               sphere_radius_we_i = 0;
  logic [RAD_W-1:0]   sphere_radius_i = '0;
  logic               done_o;
  logic [DIST_W-1:0]  distance_o;
  int                 mismatch_count;
  int                 pending;
  int                 quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  haversine_distance_top uut (.*);

  haversine_distance_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o),
    .first_latitude_i, .first_longitude_i, .second_latitude_i, .second_longitude_i,
    .sphere_radius_we_i, .sphere_radius_i, .done_i(done_o), .distance_i(distance_o),
    .mismatch_count_o(mismatch_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_pair(int lat1, int lon1, int lat2, int lon2);
    @(negedge clk_i);
    first_latitude_i = lat1[29:0];
    first_longitude_i = lon1[30:0];
    second_latitude_i = lat2[29:0];
    second_longitude_i = lon2[30:0];
    start_i = 1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic hold_off(int n);
    @(negedge clk_i);
    start_i = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic set_radius(logic [RAD_W-1:0] r);
    hold_off(0);
    wait (pending == 0);
    repeat (LATENCY) @(negedge clk_i);
    sphere_radius_i = r;
    sphere_radius_we_i = 1;
    @(negedge clk_i);
    sphere_radius_we_i = 0;
  endtask

  function automatic int rand_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  task automatic random_pair();
    int lat1, lon1, lat2, lon2;
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) begin
      // raw bits across the whole port width, out of range included
      lat1 = $urandom; lon1 = $urandom; lat2 = $urandom; lon2 = $urandom;
    end else begin
      lat1 = rand_span(LAT_MAX);
      lon1 = rand_span(LON_MAX);
      if (sel < 40) begin
        lat2 = lat1 + rand_span(1 << $urandom_range(20));
        lon2 = lon1 + rand_span(1 << $urandom_range(20));
      end else if (sel < 50) begin
        lat2 = -lat1;
        lon2 = lon1 > 0 ? lon1 - LON_MAX : lon1 + LON_MAX;
      end else begin
        lat2 = rand_span(LAT_MAX);
        lon2 = rand_span(LON_MAX);
      end
    end
    send_pair(lat1, lon1, lat2, lon2);
  endtask

  // each cycle is idle with the given chance
  task automatic random_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      while (int'($urandom_range(99)) < idle_pct) hold_off(0);
      random_pair();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed corners at reset radius
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(123456789, 400000000, 123456789, 400000000);
    send_pair(100, 200, 101, 201);
    send_pair(LAT_MAX / 2, 0, -LAT_MAX / 2, LON_MAX);
    // beyond ninety degrees and full-width extremes
    send_pair((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30));
    send_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1);
    send_pair(LAT_MAX + 1000, 0, LAT_MAX - 1000, 0);
    send_pair(0, -(1 << 30), 0, (1 << 30) - 1);
    send_pair(-1, -1, -1, -1);

    set_radius('0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(12345, 678, -9999, 4242);
    set_radius(24'd1);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, 0, 0, LON_MAX);
    set_radius('1);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(1, 1, 2, 2);

    set_radius(RADIUS_RESET);
    random_phase(550, 21);
    set_radius(24'($urandom_range(1, 24'hFFFFFF)));
    random_phase(500, 66);
    // sender waits out every outstanding result once
    hold_off(0);
    wait (pending == 0);
    random_phase(50, 0);
    set_radius('1);
    random_phase(500, 0);

    hold_off(0);
    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/hvd_pkg.sv
src/hvd_rot.sv
src/haversine_distance_top.sv
src/haversine_distance_checker.sv
dv/haversine_distance_checker.sv
dv/tb.sv
